FILE: hw/rtl/lbba_pkg.sv
package lbba_pkg;

	localparam int COORD_W    = 10;
	localparam int SIZE_W     = 11;
	localparam int LABEL_W    = 32;
	localparam int ENTRY_W    = 10;
	localparam int COUNT_W    = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [SIZE_W-1:0]  MAX_EXTENT      = 11'd1024;
	localparam logic [SIZE_W-1:0]  SIZE_RESET      = 11'd1024;
	localparam logic [ENTRY_W-1:0] MAX_LABEL_RESET = 10'd1023;
	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

	typedef enum logic [1:0] {
		ACT_VOXEL   = 2'd0,
		ACT_READ    = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_RESTART = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_FAST = 2'd0,
		CFG_SIZE_MID  = 2'd1,
		CFG_SIZE_SLOW = 2'd2,
		CFG_MAX_LABEL = 2'd3
	} cfg_idx_t;

	// one table entry, min fields are one bit wider to hold the axis size
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [COORD_W-1:0] max_slow;
		logic [COORD_W-1:0] max_mid;
		logic [COORD_W-1:0] max_fast;
		logic [SIZE_W-1:0]  min_slow;
		logic [SIZE_W-1:0]  min_mid;
		logic [SIZE_W-1:0]  min_fast;
	} entry_t;

	// size register as used: zero acts as one, clamp at the largest extent
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s == '0) begin
			r = SIZE_W'(1);
		end else if (s > MAX_EXTENT) begin
			r = MAX_EXTENT;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/lbba_if.sv
interface lbba_cmd_if import lbba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [LABEL_W-1:0] label;

	modport source (output valid, output action, output label, input ready);
	modport sink (input valid, input action, input label, output ready);
endinterface

interface lbba_stats_if import lbba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ENTRY_W-1:0] entry_label;
	logic [SIZE_W-1:0]  min_fast;
	logic [SIZE_W-1:0]  min_mid;
	logic [SIZE_W-1:0]  min_slow;
	logic [COORD_W-1:0] max_fast;
	logic [COORD_W-1:0] max_mid;
	logic [COORD_W-1:0] max_slow;
	logic [COUNT_W-1:0] voxel_count;

	modport source (
		output valid, output entry_label,
		output min_fast, output min_mid, output min_slow,
		output max_fast, output max_mid, output max_slow,
		output voxel_count, input ready
	);
	modport sink (
		input valid, input entry_label,
		input min_fast, input min_mid, input min_slow,
		input max_fast, input max_mid, input max_slow,
		input voxel_count, output ready
	);
endinterface

FILE: hw/rtl/lbba_ram.sv
module lbba_ram #(
	parameter int WIDTH = 94,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/label_bounding_box_accumulator.sv
// Label bounding-box accumulator. Voxel labels of a 3D volume come in raster order
// (fast axis first) on the cmd channel; the block counts the voxel position itself and
// wraps to the origin after the last voxel of the configured extents. For each label up
// to max_label one table entry holds the min and max coordinate per axis and a saturating
// voxel count. Other cmd actions clear one entry, read one entry out on the stats channel,
// or restart the position. Entries hold garbage after reset: clear every label before it
// is used; there is no clearing pass, so the block takes items right after reset.
// Rate: one item per clock for every action unless cmd stalls. The table is a single
// memory with a registered read: it is read when an item is taken and written back in
// the cycle after, a one-entry write bypass covering back-to-back hits on the same label.
// A read result moves from the update stage into the output register, which raises stats
// valid; only a read whose result cannot move there (stats held off) stalls cmd.
module label_bounding_box_accumulator import lbba_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lbba_cmd_if.sink              cmd,
	lbba_stats_if.source          stats
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int ENT_W  = $bits(entry_t);

	// configuration
	logic [SIZE_W-1:0]  size_fast_q, size_mid_q, size_slow_q;
	logic [ENTRY_W-1:0] max_label_q;
	logic [SIZE_W-1:0]  eff_fast, eff_mid, eff_slow;

	// voxel position
	logic [COORD_W-1:0] pos_fast_q, pos_mid_q, pos_slow_q;
	logic [COORD_W-1:0] pos_fast_d, pos_mid_d, pos_slow_d;
	logic [COORD_W-1:0] inc_fast, inc_mid, inc_slow;

	// accept side
	logic cmd_acc;
	logic trk_in;

	// update stage
	logic               vld_s1;
	action_t            act_s1;
	logic               trk_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [ENTRY_W-1:0] lbl_s1;
	logic [COORD_W-1:0] cf_s1, cm_s1, cs_s1;
	logic               res_s1;
	logic               adv_s1;

	// table and write bypass
	logic [ENT_W-1:0]  ram_rdata;
	logic              ram_we;
	entry_t            ram_wdata;
	logic              fwd_vld_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	entry_t            fwd_data_q;
	entry_t            cur;
	entry_t            upd;
	entry_t            clr;

	// output register
	logic               out_vld_q;
	entry_t             out_ent_q;
	logic [ENTRY_W-1:0] out_lbl_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_fast_q <= SIZE_RESET;
			size_mid_q  <= SIZE_RESET;
			size_slow_q <= SIZE_RESET;
			max_label_q <= MAX_LABEL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SIZE_FAST: size_fast_q <= cfg_data;
				CFG_SIZE_MID:  size_mid_q  <= cfg_data;
				CFG_SIZE_SLOW: size_slow_q <= cfg_data;
				CFG_MAX_LABEL: max_label_q <= cfg_data[ENTRY_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_fast = eff_size(size_fast_q);
	assign eff_mid  = eff_size(size_mid_q);
	assign eff_slow = eff_size(size_slow_q);

	// ---------------------------------------------------------- accept side
	assign cmd.ready = !vld_s1 || adv_s1;
	assign cmd_acc   = cmd.valid && cmd.ready;

	// an index is tracked when it fits the table and is not above max_label
	assign trk_in = (cmd.label[LABEL_W-1:ENTRY_W] == '0)
		&& (cmd.label[ENTRY_W-1:0] <= max_label_q)
		&& (cmd.label < LABEL_W'(TABLE_DEPTH));

	// raster advance: an axis wraps when it reaches its size or rolls over
	// its 10-bit range; a position left past a lowered size wraps on the next step
	always_comb begin
		inc_fast   = pos_fast_q + COORD_W'(1);
		inc_mid    = pos_mid_q + COORD_W'(1);
		inc_slow   = pos_slow_q + COORD_W'(1);
		pos_fast_d = inc_fast;
		pos_mid_d  = pos_mid_q;
		pos_slow_d = pos_slow_q;
		if (({1'b0, inc_fast} >= eff_fast) || (inc_fast == '0)) begin
			pos_fast_d = '0;
			pos_mid_d  = inc_mid;
			if (({1'b0, inc_mid} >= eff_mid) || (inc_mid == '0)) begin
				pos_mid_d  = '0;
				pos_slow_d = inc_slow;
				if ({1'b0, inc_slow} >= eff_slow) begin
					pos_slow_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_fast_q <= '0;
			pos_mid_q  <= '0;
			pos_slow_q <= '0;
		end else if (cmd_acc) begin
			case (action_t'(cmd.action))
				ACT_VOXEL: begin
					pos_fast_q <= pos_fast_d;
					pos_mid_q  <= pos_mid_d;
					pos_slow_q <= pos_slow_d;
				end
				ACT_RESTART: begin
					pos_fast_q <= '0;
					pos_mid_q  <= '0;
					pos_slow_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------- update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	// item fields and the coordinates it was seen at, before the advance
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			act_s1  <= action_t'(cmd.action);
			trk_s1  <= trk_in;
			addr_s1 <= cmd.label[ADDR_W-1:0];
			lbl_s1  <= cmd.label[ENTRY_W-1:0];
			cf_s1   <= pos_fast_q;
			cm_s1   <= pos_mid_q;
			cs_s1   <= pos_slow_q;
		end
	end

	// only a read with a result can hold the stage
	assign res_s1 = vld_s1 && trk_s1 && (act_s1 == ACT_READ);
	assign adv_s1 = !res_s1 || !out_vld_q || stats.ready;

	// ------------------------------------------------------------- the table
	lbba_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.re   (cmd_acc),
		.raddr(cmd.label[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// last write is kept: it covers the write that lands in the cycle this item read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (ram_we) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= ram_wdata;
		end
	end

	assign cur = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : entry_t'(ram_rdata);

	// voxel merge: widen box to the current coordinate, count saturates
	always_comb begin
		upd          = cur;
		upd.min_fast = ({1'b0, cf_s1} < cur.min_fast) ? {1'b0, cf_s1} : cur.min_fast;
		upd.min_mid  = ({1'b0, cm_s1} < cur.min_mid) ? {1'b0, cm_s1} : cur.min_mid;
		upd.min_slow = ({1'b0, cs_s1} < cur.min_slow) ? {1'b0, cs_s1} : cur.min_slow;
		upd.max_fast = (cf_s1 > cur.max_fast) ? cf_s1 : cur.max_fast;
		upd.max_mid  = (cm_s1 > cur.max_mid) ? cm_s1 : cur.max_mid;
		upd.max_slow = (cs_s1 > cur.max_slow) ? cs_s1 : cur.max_slow;
		upd.count    = (cur.count != COUNT_MAX) ? cur.count + COUNT_W'(1) : cur.count;
	end

	// cleared entry: empty box, min at the axis sizes
	always_comb begin
		clr          = '0;
		clr.min_fast = eff_fast;
		clr.min_mid  = eff_mid;
		clr.min_slow = eff_slow;
	end

	assign ram_we    = vld_s1 && trk_s1 && ((act_s1 == ACT_VOXEL) || (act_s1 == ACT_CLEAR));
	assign ram_wdata = (act_s1 == ACT_VOXEL) ? upd : clr;

	// ------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_s1 && adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (stats.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1 && adv_s1) begin
			out_ent_q <= cur;
			out_lbl_q <= lbl_s1;
		end
	end

	assign stats.valid       = out_vld_q;
	assign stats.entry_label = out_lbl_q;
	assign stats.min_fast    = out_ent_q.min_fast;
	assign stats.min_mid     = out_ent_q.min_mid;
	assign stats.min_slow    = out_ent_q.min_slow;
	assign stats.max_fast    = out_ent_q.max_fast;
	assign stats.max_mid     = out_ent_q.max_mid;
	assign stats.max_slow    = out_ent_q.max_slow;
	assign stats.voxel_count = out_ent_q.count;

	// ------------------------------------------------------------ assertions
`ifndef ASSERT_OFF
	// a read item never writes the table back
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !res_s1)
		else $error("table write while a read result is pending");

	// a restart puts the position back at the origin
	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && (cmd.action == ACT_RESTART))
		|=> (pos_fast_q == '0 && pos_mid_q == '0 && pos_slow_q == '0))
		else $error("position not at origin after restart");

	// a read result that leaves the stage is held in the output register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1 && adv_s1) |=> (out_vld_q && (out_lbl_q == $past(lbl_s1))))
		else $error("read result lost on its way to stats");
`endif

endmodule
